### hdl/otu_pkg.sv
// ----------------------------------------------------------------------------
// otu_pkg
// Shared constants, codes and types of the outstanding ID tracker.
// ----------------------------------------------------------------------------
package otu_pkg;

  localparam int TABLE_DEPTH   = 8;
  localparam int HISTORY_DEPTH = 128;

  // The ring of recent IDs is stored in rows of several entries each.
  localparam int HIST_LANES = 8;
  localparam int HIST_ROWS  = (HISTORY_DEPTH + HIST_LANES - 1) / HIST_LANES;

  localparam int LANE_W = $clog2(HIST_LANES);
  localparam int ROW_W  = (HIST_ROWS > 1) ? $clog2(HIST_ROWS) : 1;
  localparam int RIDX_W = ROW_W + LANE_W;
  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int LEN_W   = 11;
  localparam int TMO_W   = 16;
  localparam int STAT_W  = 3;
  localparam int OCC_W   = 4;
  localparam int OSLOT_W = 3;

  localparam logic [ID_W-1:0] ID_NULL  = 8'h00;
  localparam logic [ID_W-1:0] ID_ALL1S = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_PROPOSE = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_NOT_FOUND  = 3'd2,
    STAT_REJECTED   = 3'd3,
    STAT_BAD_LENGTH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

### hdl/otu_ctrl.sv
// ----------------------------------------------------------------------------
// otu_ctrl
// Tracker sequencer: accepts a request, scans the ring on a propose, commits.
// ----------------------------------------------------------------------------
module otu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  input  otu_pkg::dp_stat_t   stat,
  output otu_pkg::ctrl_cmd_t  cmd
);
  import otu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_PROPOSE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/otu_dp.sv
// ----------------------------------------------------------------------------
// otu_dp
// Datapath of the tracker: slot table, ring memory, scan and result register.
// ----------------------------------------------------------------------------
module otu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  otu_pkg::ctrl_cmd_t  cmd,
  output otu_pkg::dp_stat_t   stat,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_id,
  input  logic [10:0]         in_length,
  input  logic [15:0]         in_timeout,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [3:0]          out_occupancy,
  output logic [2:0]          out_slot
);
  import otu_pkg::*;

  // Latched request.
  logic [OP_W-1:0]  op_r;
  logic [ID_W-1:0]  id_r;
  logic [LEN_W-1:0] len_r;
  logic [TMO_W-1:0] tmo_r;

  // Slot table.
  logic [TABLE_DEPTH-1:0] slot_valid_r;
  logic [ID_W-1:0]        slot_id_r  [TABLE_DEPTH];
  logic [LEN_W-1:0]       slot_len_r [TABLE_DEPTH];
  logic [TMO_W-1:0]       slot_tmo_r [TABLE_DEPTH];
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;

  // Ring of recent IDs.
  logic [HIST_LANES-1:0][ID_W-1:0] ring_mem [HIST_ROWS];
  logic [HIST_LANES-1:0][ID_W-1:0] ring_rdata_r;
  logic [ROW_W-1:0]                rd_row;
  logic [ROW_W-1:0]                scan_row_r;
  logic [RIDX_W-1:0]               ptr_r;
  logic                            wrapped_r;
  logic                            hit_r;
  logic                            row_hit;
  logic                            ring_we;

  // Result register.
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [OCC_W-1:0]    out_occ_r;
  logic [OSLOT_W-1:0]  out_slot_r;

  // Decision.
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              match_found;
  logic [SLOT_W-1:0] match_idx;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              do_add;
  logic              do_remove;
  logic [CNT_W+OCC_W-1:0]    occ_ext;
  logic [SLOT_W+OSLOT_W-1:0] slot_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      id_r  <= in_id;
      len_r <= in_length;
      tmo_r <= in_timeout;
    end
  end

  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (slot_valid_r[i] && (slot_id_r[i] == id_r)) begin
        match_found = 1'b1;
        match_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    res_status = STAT_REJECTED;
    res_slot   = '0;
    do_add     = 1'b0;
    do_remove  = 1'b0;
    ring_we    = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        if (len_r == '0) begin
          res_status = STAT_BAD_LENGTH;
        end else if (free_found) begin
          res_status = STAT_OK;
          res_slot   = free_idx;
          do_add     = cmd.commit;
        end else begin
          res_status = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if ((id_r != ID_NULL) && match_found) begin
          res_status = STAT_OK;
          res_slot   = match_idx;
          do_remove  = cmd.commit;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      OP_PROPOSE: begin
        if ((id_r != ID_NULL) && (id_r != ID_ALL1S) && !match_found && !hit_r) begin
          res_status = STAT_OK;
          ring_we    = cmd.commit;
        end
      end
      default: begin
        res_status = STAT_REJECTED;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (op_r == OP_ADD && res_status == STAT_OK) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (op_r == OP_REMOVE && res_status == STAT_OK && cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      cnt_r        <= '0;
    end else begin
      if (do_add) begin
        slot_valid_r[free_idx] <= 1'b1;
      end
      if (do_remove) begin
        slot_valid_r[match_idx] <= 1'b0;
      end
      if (cmd.commit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      slot_id_r[free_idx]  <= id_r;
      slot_len_r[free_idx] <= len_r;
      slot_tmo_r[free_idx] <= tmo_r;
    end
    if (do_remove) begin
      slot_id_r[match_idx]  <= '0;
      slot_len_r[match_idx] <= '0;
      slot_tmo_r[match_idx] <= '0;
    end
  end

  // The ring is read one row per cycle; row 0 is presented while idle.
  always_comb begin
    rd_row = '0;
    if (cmd.scan && !stat.scan_last) begin
      rd_row = scan_row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ptr_r[RIDX_W-1:LANE_W]][ptr_r[LANE_W-1:0]] <= id_r;
    end
    ring_rdata_r <= ring_mem[rd_row];
  end

  always_comb begin
    logic [RIDX_W-1:0] idx;
    logic              live;
    row_hit = 1'b0;
    for (int l = 0; l < HIST_LANES; l++) begin
      idx  = {scan_row_r, LANE_W'(l)};
      live = wrapped_r ? ({1'b0, idx} < (RIDX_W + 1)'(HISTORY_DEPTH)) : (idx < ptr_r);
      if (live && (ring_rdata_r[l] == id_r)) begin
        row_hit = 1'b1;
      end
    end
  end

  assign stat.scan_last = (scan_row_r == ROW_W'(HIST_ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      wrapped_r  <= 1'b0;
      scan_row_r <= '0;
      hit_r      <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_row_r <= '0;
        hit_r      <= 1'b0;
      end else if (cmd.scan) begin
        scan_row_r <= scan_row_r + ROW_W'(1);
        hit_r      <= hit_r | row_hit;
      end
      if (ring_we) begin
        if (ptr_r == RIDX_W'(HISTORY_DEPTH - 1)) begin
          ptr_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + RIDX_W'(1);
        end
      end
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;

  assign occ_ext  = {{OCC_W{1'b0}}, cnt_nxt};
  assign slot_ext = {{OSLOT_W{1'b0}}, res_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_occ_r    <= occ_ext[OCC_W-1:0];
      out_slot_r   <= slot_ext[OSLOT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;
  assign out_slot      = out_slot_r;

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == int'(cnt_r))
    else $error("Occupancy count differs from the number of valid slots.");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("Result committed while the output register was held.");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ptr_r} < (RIDX_W + 1)'(HISTORY_DEPTH))
    else $error("Ring pointer beyond the ring depth.");

  a_scan_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (int'(scan_row_r) < HIST_ROWS))
    else $error("Ring scan ran past the last row.");

endmodule

### hdl/outstanding_id_tracker_unit.sv
// ----------------------------------------------------------------------------
// outstanding_id_tracker_unit
// Tracks outstanding packet IDs in a slot table and vets new candidate IDs
// against the table and a ring of recently issued IDs.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake             Payload
//   in        request     in_valid / in_stall   in_op, in_id, in_length, in_timeout
//   out       result      out_valid / out_stall out_status, out_occupancy, out_slot
//
// An add or remove request is accepted in the idle state; its result is registered
// on commit in the result state, and the unit takes the next request in idle.
// A propose request goes from idle through the scan state, which reads the ring,
// to the result state, where its result is registered on commit; no new request
// is taken until idle. The ring delivers one row of HIST_LANES entries per cycle.
// A result waiting in a stalled output register holds the next result back.
// Reset is synchronous and empties the table and the ring at once.
//
module outstanding_id_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_id,
  input  logic [10:0] in_length,
  input  logic [15:0] in_timeout,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_occupancy,
  output logic [2:0]  out_slot
);
  import otu_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  otu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  otu_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_op),
    .in_id         (in_id),
    .in_length     (in_length),
    .in_timeout    (in_timeout),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .out_slot      (out_slot)
  );

endmodule
